@@ sv/ccfs_pkg.sv @@
// shared types and constants for the channel communication fault supervisor
`default_nettype none

package ccfs_pkg;

    localparam int unsigned CNT_W    = 4;
    localparam int unsigned CH_W     = 9;
    localparam int unsigned EVCH_W   = 10;
    localparam int unsigned FCOUNT_W = 10;
    localparam int unsigned REC_W    = 9;
    localparam int unsigned ACT_W    = 10;
    localparam int unsigned CFG_W    = 10;
    localparam int unsigned CHX_W    = 11;

    localparam logic [CNT_W-1:0] CNT_MAX       = 4'hF;
    localparam logic [CNT_W-1:0] LIMIT_RESET   = 4'd8;
    localparam logic [ACT_W-1:0] ACTIVE_RESET  = 10'd512;
    localparam logic [ACT_W-1:0] HALVE_ABOVE   = 10'd256;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_MASK  = 2'd2,
        REQ_EVAL  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_RAISE = 2'd1,
        EV_CLEAR = 2'd2
    } event_t;

    typedef enum logic {
        CFG_ERROR_LIMIT     = 1'b0,
        CFG_ACTIVE_CHANNELS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [CH_W-1:0] channel;
        logic [3:0]      error_increment;
        logic            mask_value;
        logic [1:0]      system_faults;
        logic            pending_fault;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          event_kind;
        logic [EVCH_W-1:0]   event_channel;
        logic [FCOUNT_W-1:0] fault_count;
        logic                comm_fault;
        logic                system_fault;
        logic                total_fault;
        logic                beep_on;
        logic [REC_W-1:0]    record_index;
        logic [CNT_W-1:0]    counter_value;
    } out_beat_t;

    typedef struct packed {
        logic            mask;
        logic            fault;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_full;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/ccfs_ctrl.sv @@
// sequencer for the clearing pass and the read-modify-write of one item
`default_nettype none

module ccfs_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  ccfs_pkg::dp_sts_t    sts,
    output ccfs_pkg::ctl_cmd_t   cmd
);

    ccfs_pkg::state_t state_reg;
    ccfs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccfs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ccfs_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ccfs_pkg::ST_IDLE;
                end
            end
            ccfs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ccfs_pkg::ST_EXEC;
                end
            end
            ccfs_pkg::ST_EXEC:
            begin
                if (!sts.out_full)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ccfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ccfs_pkg::ST_CLEAR;
            end
        endcase
    end

    // an accepted beat always moves on to the execute step
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ccfs_pkg::ST_EXEC))
        else $error("accepted beat did not reach execute");

    a_clear_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ccfs_pkg::ST_CLEAR && !sts.clear_last)
            |=> (state_reg == ccfs_pkg::ST_CLEAR))
        else $error("left clearing pass early");

    a_exec_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (state_reg == ccfs_pkg::ST_EXEC) && !sts.out_full)
        else $error("execute issued while output full");

endmodule

`default_nettype wire

@@ sv/ccfs_dp.sv @@
// channel table, fault bookkeeping, configuration registers and output register
`default_nettype none

module ccfs_dp #(
    parameter int unsigned CHANNELS     = 512,
    parameter int unsigned RECORD_LIMIT = 500
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  ccfs_pkg::ctl_cmd_t     cmd,
    output ccfs_pkg::dp_sts_t      sts,
    input  ccfs_pkg::in_beat_t     in_data,
    input  wire                    cfg_valid,
    input  wire                    cfg_index,
    input  wire [ccfs_pkg::CFG_W-1:0] cfg_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output ccfs_pkg::out_beat_t    out_data
);

    localparam int unsigned AW = $clog2(CHANNELS);
    localparam int unsigned FW = $clog2(CHANNELS + 1);
    localparam logic [ccfs_pkg::CHX_W-1:0] CH_END = ccfs_pkg::CHX_W'(CHANNELS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);
    localparam logic [ccfs_pkg::REC_W-1:0] REC_LIMIT = ccfs_pkg::REC_W'(RECORD_LIMIT);

    ccfs_pkg::entry_t mem [CHANNELS];
    ccfs_pkg::entry_t rdata_reg;
    ccfs_pkg::in_beat_t beat_reg;

    logic [AW-1:0] clr_addr_reg;
    logic [ccfs_pkg::CNT_W-1:0] limit_reg;
    logic [ccfs_pkg::ACT_W-1:0] active_reg;
    logic [FW-1:0] total_reg, total_next;
    logic [ccfs_pkg::REC_W-1:0] record_reg, record_next;
    logic beep_reg, beep_next;
    logic out_valid_reg, out_valid_next;
    ccfs_pkg::out_beat_t out_data_reg, out_data_next;

    logic [ccfs_pkg::CHX_W-1:0] ch_in_ext, ch_ext;
    logic [AW-1:0] rd_addr, wr_addr;
    logic in_range, active_ch;
    ccfs_pkg::entry_t entry_next;
    logic [ccfs_pkg::CNT_W:0] sum;
    logic [ccfs_pkg::CNT_W-1:0] thr;
    logic [1:0] sys_n;
    logic [FW:0] fcount;
    logic [11:0] fcount_wide;
    ccfs_pkg::event_t kind;

    assign ch_in_ext = {2'b00, in_data.channel};
    assign rd_addr   = ch_in_ext[AW-1:0];
    assign ch_ext    = {2'b00, beat_reg.channel};
    assign wr_addr   = ch_ext[AW-1:0];

    assign sts.clear_last = (clr_addr_reg == LAST_ADDR);
    assign sts.out_full   = out_valid_reg && out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.exec && in_range)
        begin
            mem[wr_addr] <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rdata_reg <= mem[rd_addr];
            beat_reg  <= in_data;
        end
        if (cmd.exec)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        in_range   = (ch_ext < CH_END);
        active_ch  = (ch_ext < {1'b0, active_reg});
        thr        = (active_reg > ccfs_pkg::HALVE_ABOVE) ? (limit_reg >> 1) : limit_reg;
        sum        = {1'b0, rdata_reg.cnt} + {1'b0, beat_reg.error_increment};
        entry_next = rdata_reg;
        total_next = total_reg;
        record_next = record_reg;
        beep_next  = beep_reg;
        kind       = ccfs_pkg::EV_NONE;
        if (in_range)
        begin
            case (beat_reg.req_type)
                ccfs_pkg::REQ_ADD:
                begin
                    entry_next.cnt = sum[ccfs_pkg::CNT_W] ? ccfs_pkg::CNT_MAX
                                                          : sum[ccfs_pkg::CNT_W-1:0];
                end
                ccfs_pkg::REQ_CLEAR:
                begin
                    entry_next.cnt = '0;
                end
                ccfs_pkg::REQ_MASK:
                begin
                    entry_next.mask = beat_reg.mask_value;
                end
                default:
                begin
                    if (active_ch && !rdata_reg.mask)
                    begin
                        if (!rdata_reg.fault)
                        begin
                            if (rdata_reg.cnt >= thr)
                            begin
                                entry_next.fault = 1'b1;
                                total_next = total_reg + FW'(1);
                                kind       = ccfs_pkg::EV_RAISE;
                                beep_next  = 1'b1;
                                record_next = (record_reg < REC_LIMIT)
                                              ? record_reg + ccfs_pkg::REC_W'(1)
                                              : ccfs_pkg::REC_W'(1);
                            end
                        end
                        else if (rdata_reg.cnt < thr)
                        begin
                            entry_next.fault = 1'b0;
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - FW'(1);
                            end
                            kind = ccfs_pkg::EV_CLEAR;
                        end
                    end
                end
            endcase
        end
        sys_n       = {1'b0, beat_reg.system_faults[0]} + {1'b0, beat_reg.system_faults[1]};
        fcount      = {1'b0, total_next} + (FW + 1)'(sys_n);
        fcount_wide = 12'(fcount);
        if (in_range && beat_reg.req_type == ccfs_pkg::REQ_EVAL && fcount == '0
            && !beat_reg.pending_fault)
        begin
            beep_next = 1'b0;
        end

        out_data_next.event_kind    = kind;
        out_data_next.event_channel = (kind == ccfs_pkg::EV_NONE) ? '0
                                      : ch_ext[ccfs_pkg::EVCH_W-1:0] + ccfs_pkg::EVCH_W'(1);
        out_data_next.fault_count   = fcount_wide[ccfs_pkg::FCOUNT_W-1:0];
        out_data_next.comm_fault    = (total_next != '0);
        out_data_next.system_fault  = (beat_reg.system_faults != 2'b00);
        out_data_next.total_fault   = (fcount != '0) || beat_reg.pending_fault;
        out_data_next.beep_on       = beep_next;
        out_data_next.record_index  = record_next;
        out_data_next.counter_value = in_range ? entry_next.cnt : '0;

        out_valid_next = cmd.exec ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            limit_reg     <= ccfs_pkg::LIMIT_RESET;
            active_reg    <= ccfs_pkg::ACTIVE_RESET;
            total_reg     <= '0;
            record_reg    <= '0;
            beep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr && !sts.clear_last)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ccfs_pkg::CFG_ERROR_LIMIT:
                    begin
                        limit_reg <= cfg_data[ccfs_pkg::CNT_W-1:0];
                    end
                    ccfs_pkg::CFG_ACTIVE_CHANNELS:
                    begin
                        active_reg <= cfg_data[ccfs_pkg::ACT_W-1:0];
                    end
                    default:
                    begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end
            if (cmd.exec)
            begin
                total_reg  <= total_next;
                record_reg <= record_next;
                beep_reg   <= beep_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_record_bound: assert property (@(posedge clk) disable iff (!rst_n)
        record_reg <= REC_LIMIT)
        else $error("record index beyond limit");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= FW'(CHANNELS))
        else $error("fault total beyond channel count");

    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.exec))
        else $error("output beat without execute");

endmodule

`default_nettype wire

@@ sv/channel_comm_fault_supervisor.sv @@
// top level of the channel communication fault supervisor
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall   ccfs_pkg::in_beat_t
//  out      output     out_valid/out_stall ccfs_pkg::out_beat_t
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one beat has two steps: accept with table read, then update and write back once the output has room
// the single-port channel table sets that split: one read and at most one write per beat
// after reset a clearing pass zeroes every table entry in turn; in stays stalled
// a result waits in the output register; the next beat is accepted meanwhile
// cfg writes are taken in every cycle, the clearing pass included
`default_nettype none

module channel_comm_fault_supervisor #(
    parameter int unsigned CHANNELS     = 512,
    parameter int unsigned RECORD_LIMIT = 500
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  ccfs_pkg::in_beat_t           in_data,
    output logic                         out_valid,
    input  wire                          out_stall,
    output ccfs_pkg::out_beat_t          out_data,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_index,
    input  wire [ccfs_pkg::CFG_W-1:0]    cfg_data
);

    ccfs_pkg::ctl_cmd_t cmd;
    ccfs_pkg::dp_sts_t  sts;

    assign cfg_ready = 1'b1;

    ccfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccfs_dp #(
        .CHANNELS     (CHANNELS),
        .RECORD_LIMIT (RECORD_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ tb/tb_channel_comm_fault_supervisor.sv @@
// self-checking testbench for the channel communication fault supervisor
module tb_channel_comm_fault_supervisor;

    localparam int unsigned N_CH     = 512;
    localparam int unsigned REC_WRAP = 500;

    typedef struct {
        ccfs_pkg::in_beat_t  beat;
        bit                  typed;
        ccfs_pkg::out_beat_t want;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    ccfs_pkg::in_beat_t            in_data;
    logic                          out_valid;
    logic                          out_stall;
    ccfs_pkg::out_beat_t           out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [ccfs_pkg::CFG_W-1:0]    cfg_data;

    // shadow of the channel table and the global status
    logic                          mask_tbl [N_CH];
    logic                          fault_tbl [N_CH];
    logic [ccfs_pkg::CNT_W-1:0]    count_tbl [N_CH];
    int unsigned                   faulted_total;
    int unsigned                   record_num;
    logic                          beep_q;
    logic [ccfs_pkg::CNT_W-1:0]    limit_q;
    logic [ccfs_pkg::ACT_W-1:0]    active_q;

    ccfs_pkg::out_beat_t           status_q [$];
    ccfs_pkg::out_beat_t           want_s;
    row_t                          plan [$];
    int unsigned                   mismatches = 0;
    bit                            quiet;

    channel_comm_fault_supervisor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    function automatic ccfs_pkg::in_beat_t mk_in(input ccfs_pkg::req_t req,
                                                 input int unsigned ch,
                                                 input int unsigned inc,
                                                 input int unsigned mval,
                                                 input int unsigned sys,
                                                 input int unsigned pend);
        ccfs_pkg::in_beat_t b;
        b.req_type        = req;
        b.channel         = ch[ccfs_pkg::CH_W-1:0];
        b.error_increment = inc[3:0];
        b.mask_value      = mval[0];
        b.system_faults   = sys[1:0];
        b.pending_fault   = pend[0];
        return b;
    endfunction

    function automatic ccfs_pkg::out_beat_t mk_out(input ccfs_pkg::event_t kind,
                                                   input int unsigned evch,
                                                   input int unsigned fcount,
                                                   input int unsigned comm,
                                                   input int unsigned sys,
                                                   input int unsigned total,
                                                   input int unsigned beep,
                                                   input int unsigned rec,
                                                   input int unsigned cnt);
        ccfs_pkg::out_beat_t r;
        r.event_kind    = kind;
        r.event_channel = evch[ccfs_pkg::EVCH_W-1:0];
        r.fault_count   = fcount[ccfs_pkg::FCOUNT_W-1:0];
        r.comm_fault    = comm[0];
        r.system_fault  = sys[0];
        r.total_fault   = total[0];
        r.beep_on       = beep[0];
        r.record_index  = rec[ccfs_pkg::REC_W-1:0];
        r.counter_value = cnt[ccfs_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic ccfs_pkg::in_beat_t rand_beat(input ccfs_pkg::req_t req,
                                                     input logic [ccfs_pkg::CH_W-1:0] ch);
        ccfs_pkg::in_beat_t b;
        b.req_type        = req;
        b.channel         = ch;
        b.error_increment = 4'($urandom_range(15));
        b.mask_value      = (req == ccfs_pkg::REQ_MASK) ? ($urandom_range(99) < 30)
                                                        : 1'($urandom_range(1));
        b.system_faults   = $urandom_range(1) ? 2'($urandom_range(3)) : 2'b00;
        b.pending_fault   = ($urandom_range(99) < 20);
        return b;
    endfunction

    function automatic logic [ccfs_pkg::CH_W-1:0] pick_channel();
        int unsigned hi;
        hi = (32'(active_q) >= N_CH) ? N_CH - 1 : 32'(active_q) - 1;
        if ($urandom_range(3) != 0)
            return ccfs_pkg::CH_W'($urandom_range(hi));
        return ccfs_pkg::CH_W'($urandom_range(N_CH - 1));
    endfunction

    task automatic predict_status(input ccfs_pkg::in_beat_t b,
                                  output ccfs_pkg::out_beat_t r);
        logic [ccfs_pkg::CH_W-1:0]  ch;
        int unsigned                sum;
        int unsigned                fcount;
        logic [ccfs_pkg::CNT_W-1:0] thr;
        ccfs_pkg::event_t           kind;
        int unsigned                evch;
        ch   = b.channel;
        kind = ccfs_pkg::EV_NONE;
        evch = 0;
        case (b.req_type)
            ccfs_pkg::REQ_ADD:
            begin
                sum = 32'(count_tbl[ch]) + 32'(b.error_increment);
                count_tbl[ch] = (sum > 32'(ccfs_pkg::CNT_MAX)) ? ccfs_pkg::CNT_MAX
                                                               : sum[ccfs_pkg::CNT_W-1:0];
            end
            ccfs_pkg::REQ_CLEAR:
                count_tbl[ch] = '0;
            ccfs_pkg::REQ_MASK:
                mask_tbl[ch] = b.mask_value;
            default:
            begin
                if ({1'b0, ch} < active_q && !mask_tbl[ch])
                begin
                    thr = (active_q > ccfs_pkg::HALVE_ABOVE) ? (limit_q >> 1) : limit_q;
                    if (!fault_tbl[ch])
                    begin
                        if (count_tbl[ch] >= thr)
                        begin
                            fault_tbl[ch] = 1'b1;
                            faulted_total++;
                            kind   = ccfs_pkg::EV_RAISE;
                            evch   = 32'(ch) + 1;
                            beep_q = 1'b1;
                            record_num = (record_num < REC_WRAP) ? record_num + 1 : 1;
                        end
                    end
                    else if (count_tbl[ch] < thr)
                    begin
                        fault_tbl[ch] = 1'b0;
                        if (faulted_total > 0)
                            faulted_total--;
                        kind = ccfs_pkg::EV_CLEAR;
                        evch = 32'(ch) + 1;
                    end
                end
            end
        endcase
        fcount = faulted_total + 32'(b.system_faults[0]) + 32'(b.system_faults[1]);
        if (b.req_type == ccfs_pkg::REQ_EVAL && fcount == 0 && !b.pending_fault)
            beep_q = 1'b0;
        r = mk_out(kind, evch, fcount, 32'(faulted_total != 0),
                   32'(b.system_faults != 2'b00), 32'(fcount != 0 || b.pending_fault),
                   32'(beep_q), record_num, 32'(count_tbl[ch]));
    endtask

    task automatic push_beat(input ccfs_pkg::in_beat_t b, input bit typed,
                             input ccfs_pkg::out_beat_t want);
        ccfs_pkg::out_beat_t pred;
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        predict_status(b, pred);
        status_q.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned lim, input int unsigned act);
        cfg_valid <= 1'b1;
        cfg_index <= ccfs_pkg::CFG_ERROR_LIMIT;
        cfg_data  <= ccfs_pkg::CFG_W'(lim);
        do @(posedge clk); while (!cfg_ready);
        limit_q   = lim[ccfs_pkg::CNT_W-1:0];
        cfg_index <= ccfs_pkg::CFG_ACTIVE_CHANNELS;
        cfg_data  <= ccfs_pkg::CFG_W'(act);
        do @(posedge clk); while (!cfg_ready);
        active_q  = act[ccfs_pkg::ACT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned                done;
        int unsigned                k;
        logic [ccfs_pkg::CH_W-1:0]  ch;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(99) < 75)
            begin
                // add errors, evaluate, maybe clear, evaluate again
                ch = pick_channel();
                k  = $urandom_range(1, 3);
                repeat (k) push_beat(rand_beat(ccfs_pkg::REQ_ADD, ch), 1'b0, '0);
                push_beat(rand_beat(ccfs_pkg::REQ_EVAL, ch), 1'b0, '0);
                if ($urandom_range(1))
                    push_beat(rand_beat(ccfs_pkg::REQ_CLEAR, ch), 1'b0, '0);
                push_beat(rand_beat(ccfs_pkg::REQ_EVAL, ch), 1'b0, '0);
                done += k + 2;
            end
            else
            begin
                push_beat(rand_beat(ccfs_pkg::req_t'($urandom_range(3)),
                                    ccfs_pkg::CH_W'($urandom_range(N_CH - 1))),
                          1'b0, '0);
                done++;
            end
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= !quiet && ($urandom_range(99) < 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", out_data);
            end
            else
            begin
                want_s = status_q.pop_front();
                if (out_data !== want_s)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %h got %h", want_s, out_data);
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ccfs_pkg::CFG_ERROR_LIMIT;
        cfg_data  <= '0;
        quiet      = 1'b0;
        mask_tbl   = '{default: 1'b0};
        fault_tbl  = '{default: 1'b0};
        count_tbl  = '{default: '0};
        faulted_total = 0;
        record_num    = 0;
        beep_q        = 1'b0;
        limit_q       = ccfs_pkg::LIMIT_RESET;
        active_q      = ccfs_pkg::ACTIVE_RESET;

        // reset limits: threshold 4
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 0, 15, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 0, 0, 0, 0, 0, 0, 15)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 0, 15, 1, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 0, 0, 0, 0, 0, 0, 15)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 0, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_RAISE, 1, 1, 1, 0, 1, 1, 1, 15)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 0, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 1, 1, 0, 1, 1, 1, 15)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_CLEAR, 0, 0, 0, 3, 1), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 3, 1, 1, 1, 1, 1, 0)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 0, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_CLEAR, 1, 0, 0, 0, 0, 0, 1, 0)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 511, 4, 0, 2, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 1, 0, 1, 1, 0, 1, 4)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_MASK, 511, 0, 1, 0, 1), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 0, 0, 0, 1, 0, 1, 4)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 511, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 0, 0, 0, 0, 0, 1, 4)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_MASK, 511, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 0, 0, 0, 0, 0, 1, 4)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 511, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_RAISE, 512, 1, 1, 0, 1, 1, 2, 4)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 256, 0, 0, 1, 1), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 2, 1, 1, 1, 1, 2, 0)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 511, 0, 1, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 1, 1, 0, 1, 1, 2, 4)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_CLEAR, 511, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 1, 1, 0, 1, 1, 2, 0)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 511, 0, 0, 0, 1), 1'b1,
                         mk_out(ccfs_pkg::EV_CLEAR, 512, 0, 0, 0, 1, 1, 2, 0)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 5, 0, 0, 0, 0), 1'b1,
                         mk_out(ccfs_pkg::EV_NONE, 0, 0, 0, 0, 0, 0, 2, 0)});
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 3, 3, 0, 1, 0), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 3, 0, 0, 2, 1), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 3, 1, 1, 0, 0), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 3, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_ADD, 255, 9, 0, 3, 0), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 255, 0, 0, 3, 1), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_MASK, 255, 0, 1, 0, 0), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_EVAL, 255, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk_in(ccfs_pkg::REQ_MASK, 255, 0, 0, 0, 0), 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            push_beat(plan[i].beat, plan[i].typed, plan[i].want);
        settle();

        // zero threshold sweep over every channel, drives the record index past its wrap
        set_config(0, 512);
        quiet = 1'b1;
        for (int i = 0; i < N_CH; i++)
            push_beat(rand_beat(ccfs_pkg::REQ_EVAL, ccfs_pkg::CH_W'(i)), 1'b0, '0);
        quiet = 1'b0;
        settle();

        set_config(15, 256);
        random_phase(120);
        settle();
        set_config(1, 300);
        random_phase(110);
        settle();
        set_config(5, 1);
        random_phase(90);
        settle();
        set_config(9, 257);
        random_phase(120);
        settle();
        set_config(15, 512);
        random_phase(120);
        settle();
        set_config(3, 100);
        random_phase(110);
        settle();
        set_config(0, 1);
        random_phase(60);
        settle();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && status_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
